/* rtl/core/i2a_pkg.sv */
// Package for the integer to ASCII digits block: word types, mode codes,
// character codes, controller states and the control interface structs.
// No dependencies.
`default_nettype none
package i2a_pkg;

  localparam int VALUE_W  = 32;
  localparam int NDIGITS  = 10;
  localparam int PTR_W    = 4;
  localparam int CNT_W    = 5;

  localparam logic [1:0] MODE_HEX  = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_SDEC = 2'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic advance;
    logic sel_sign;
  } dp_cmd_t;

  typedef struct packed {
    logic hex;
    logic neg;
    logic ptr_zero;
  } dp_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/integer_to_ascii_digits_top.sv */
// Top level of the integer to ASCII digits block: controller plus datapath.
// Depends on i2a_pkg, i2a_ctrl and i2a_datapath.
//
// Takes one number per input word (mode and 32-bit value) and returns its
// ASCII characters most significant first, one per output word, with last
// set on the final one. Hex numbers are upper case with no prefix; signed
// decimal negatives print '-' then the magnitude. One number is handled at a
// time. Decimal numbers go through the one-bit-per-cycle shift-and-add-3
// binary to BCD loop, while hex numbers skip it. in_ready is high only
// between numbers.
`default_nettype none
module integer_to_ascii_digits_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire i2a_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output i2a_pkg::out_word_t      out_data
);
  import i2a_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  i2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  i2a_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

/* rtl/core/i2a_datapath.sv */
// Datapath: operand load, shift-and-add-3 binary to BCD conversion, leading
// zero search and character selection. Depends on i2a_pkg.
`default_nettype none
module i2a_datapath (
  input  wire logic               clk,
  input  wire i2a_pkg::in_word_t  in_data,
  input  wire i2a_pkg::dp_cmd_t   cmd,
  output i2a_pkg::dp_status_t     status,
  output i2a_pkg::out_word_t      out_data
);
  import i2a_pkg::*;

  logic [VALUE_W-1:0]            bin_r, bin_nxt;
  logic [NDIGITS-1:0][3:0]       bcd_r, bcd_nxt;
  logic [PTR_W-1:0]              ptr_r, ptr_nxt;
  logic                          neg_r, neg_nxt;
  logic                          hex_r, hex_nxt;
  logic [NDIGITS-1:0][3:0]       adj;
  logic [PTR_W-1:0]              top_idx;
  logic                          load_neg;
  logic [VALUE_W-1:0]            load_mag;

  assign load_neg = (in_data.mode == MODE_SDEC) && in_data.value[VALUE_W-1];
  assign load_mag = load_neg ? (~in_data.value + 32'd1) : in_data.value;

  always_comb begin
    // Digits of five or more get three added before each doubling.
    for (int i = 0; i < NDIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
    top_idx = '0;
    for (int i = 0; i < NDIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        top_idx = PTR_W'(i);
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    ptr_nxt = ptr_r;
    neg_nxt = neg_r;
    hex_nxt = hex_r;
    if (cmd.load) begin
      neg_nxt = load_neg;
      hex_nxt = (in_data.mode == MODE_HEX);
      bin_nxt = load_mag;
      if (in_data.mode == MODE_HEX) begin
        bcd_nxt = {8'd0, in_data.value};
      end else begin
        bcd_nxt = '0;
      end
    end else if (cmd.step) begin
      // The top digit of a 32-bit value never exceeds 4, so its high bit drops out.
      bcd_nxt = {adj[NDIGITS-1][2:0], adj[NDIGITS-2:0], bin_r[VALUE_W-1]};
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
    end else if (cmd.prep) begin
      ptr_nxt = top_idx;
    end else if (cmd.advance) begin
      ptr_nxt = ptr_r - PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    ptr_r <= ptr_nxt;
    neg_r <= neg_nxt;
    hex_r <= hex_nxt;
  end

  assign status.hex      = hex_r;
  assign status.neg      = neg_r;
  assign status.ptr_zero = (ptr_r == '0);

  always_comb begin
    if (cmd.sel_sign) begin
      out_data.character = CHAR_MINUS;
      out_data.last      = 1'b0;
    end else begin
      out_data.character = digit_char(bcd_r[ptr_r]);
      out_data.last      = (ptr_r == '0);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/i2a_ctrl.sv */
// Controller state machine: sequences load, conversion, leading zero search
// and character emission. Depends on i2a_pkg.
`default_nettype none
module i2a_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire i2a_pkg::dp_status_t status,
  output i2a_pkg::dp_cmd_t         cmd
);
  import i2a_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // Hex digits are loaded directly, so conversion is skipped.
        if (status.hex) begin
          state_nxt = ST_PREP;
        end else begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(VALUE_W - 1)) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = status.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
        if (out_ready) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.ptr_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/i2a_checker.sv */
// Port-level checker for the integer to ASCII digits block, bound to the
// top level. Depends on i2a_pkg.
`default_nettype none
module i2a_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire i2a_pkg::in_word_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire i2a_pkg::out_word_t out_data
);
  import i2a_pkg::*;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // Input is never taken while characters are still being emitted.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output busy");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a word");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.character >= 8'h30 && out_data.character <= 8'h39) ||
                   (out_data.character >= 8'h41 && out_data.character <= 8'h46) ||
                   (out_data.character == CHAR_MINUS)))
    else $error("illegal character emitted");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.character == CHAR_MINUS) |-> !out_data.last)
    else $error("minus sign marked as last");

endmodule

bind integer_to_ascii_digits_top i2a_checker u_i2a_checker (.*);
`default_nettype wire

/* tb/testbench.sv */
// Testbench for integer_to_ascii_digits_top: drives random and corner-case
// numbers in every mode and checks each returned character against a
// predictor of its own. Depends on i2a_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import i2a_pkg::*;

  // The spare mode code prints as unsigned decimal.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int NUMBERS_RANDOM = 450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 60;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

  class char_checker;
    out_word_t pending_chars[$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return pending_chars.size();
    endfunction

    // Works out the characters one accepted number should produce.
    task note_number(in_word_t w);
      logic [31:0] mag;
      logic [31:0] radix;
      logic [3:0] d;
      logic [7:0] digits[$];
      logic neg;
      out_word_t c;
      neg = (w.mode == MODE_SDEC) && w.value[31];
      mag = neg ? (32'd0 - w.value) : w.value;
      radix = (w.mode == MODE_HEX) ? 32'd16 : 32'd10;
      do begin
        d = 4'(mag % radix);
        digits.push_front(d < 4'd10 ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d) - 8'd10);
        mag = mag / radix;
      end while (mag != 0);
      if (neg) begin
        c.character = CHAR_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.character = digits[i];
        c.last = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endtask

    task check_char(out_word_t got);
      out_word_t exp_c;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected character %02h last %0b", got.character, got.last));
        return;
      end
      exp_c = pending_chars.pop_front();
      if (got.character !== exp_c.character)
        report($sformatf("character %02h, expected %02h", got.character, exp_c.character));
      if (got.last !== exp_c.last)
        report($sformatf("last %0b on %02h, expected %0b", got.last, exp_c.character,
                         exp_c.last));
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  char_checker chars = new();
  int cycles = 0;
  int ready_cnt = 0;
  rx_style_t ready_style = RX_OPEN;

  integer_to_ascii_digits_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Both channels are sampled here, numbers before characters.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) chars.note_number(in_data);
    if (rst_n && out_valid && out_ready) chars.check_char(out_data);
  end

  // The receiver switches between randomly chosen stall styles.
  always @(posedge clk) begin
    ready_cnt <= ready_cnt + 1;
    if (ready_cnt % 97 == 0) ready_style <= rx_style_t'($urandom_range(0, 3));
    case (ready_style)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (ready_cnt % 4 == 0);
      default: out_ready <= ready_cnt[0];
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Holds the word until it is taken, then optionally idles for the given gap.
  task send_number(logic [1:0] mode, logic [31:0] value, int gap);
    in_valid <= 1'b1;
    in_data <= '{mode: mode, value: value};
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // It waits on the clock before polling, so the word accepted at the current edge is noted.
  task wait_all_chars();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars.pending() != 0) @(posedge clk);
  endtask

  function logic [31:0] random_value();
    logic [31:0] v;
    int k;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 20);
      1: v = $urandom;
      2: v = 32'd0 - 32'($urandom_range(1, 1000));
      3: begin
        // Products of tens and sixteens and their neighbors change the digit count.
        v = 32'd1;
        k = $urandom_range(0, 9);
        repeat (k) v = v * (($urandom_range(0, 1) == 1) ? 32'd10 : 32'd16);
        v = v + 32'($urandom_range(0, 2)) - 32'd1;
      end
      4: v = 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd1;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  task run_directed();
    send_number(MODE_HEX, 32'd0, 0);
    send_number(MODE_HEX, 32'hFFFF_FFFF, 0);
    send_number(MODE_HEX, 32'h0000_000F, 0);
    send_number(MODE_HEX, 32'h0000_0010, 0);
    send_number(MODE_HEX, 32'h89AB_CDEF, 0);
    send_number(MODE_HEX, 32'h0123_4567, 0);
    send_number(MODE_UDEC, 32'd0, 0);
    send_number(MODE_UDEC, 32'd9, 0);
    send_number(MODE_UDEC, 32'd10, 0);
    send_number(MODE_UDEC, 32'hFFFF_FFFF, 0);
    send_number(MODE_UDEC, 32'd1000000000, 0);
    send_number(MODE_UDEC, 32'd999999999, 0);
    send_number(MODE_SDEC, 32'd0, 0);
    send_number(MODE_SDEC, 32'd1, 0);
    send_number(MODE_SDEC, 32'hFFFF_FFFF, 0);
    send_number(MODE_SDEC, 32'h7FFF_FFFF, 0);
    send_number(MODE_SDEC, 32'h8000_0000, 0);
    send_number(MODE_SDEC, 32'd0 - 32'd10, 0);
    send_number(MODE_SDEC, 32'd0 - 32'd1000000000, 0);
    send_number(MODE_SPARE, 32'd0, 0);
    send_number(MODE_SPARE, 32'hFFFF_FFFF, 0);
    send_number(MODE_SPARE, 32'd123, 0);
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    logic [1:0] mode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_all_chars();
    sent = 0;
    while (sent < NUMBERS_RANDOM) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst; k++) begin
        mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
        gap = (k == burst - 1) ? $urandom_range(0, 15) : 0;
        send_number(mode, random_value(), gap);
        sent++;
        if (sent == NUMBERS_RANDOM / 2) wait_all_chars();
      end
    end
    wait_all_chars();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chars.errors == 0 && chars.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
